// ===== src/rpn_pkg.sv =====
// Shared types, constants and command codes for the RPN stack calculator.
`default_nettype none
package rpn_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_PUSH    = 4'd0,
        OP_ADD     = 4'd1,
        OP_SUB     = 4'd2,
        OP_MUL     = 4'd3,
        OP_DIV     = 4'd4,
        OP_SUM_ALL = 4'd5,
        OP_SUB_ALL = 4'd6,
        OP_MUL_ALL = 4'd7,
        OP_COPY    = 4'd8
    } t_op;

    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_FEW  = 3'd1,
        ST_FULL = 3'd2,
        ST_SAT  = 3'd3,
        ST_DIV0 = 3'd4
    } t_status;

    // Command class decided by the front end.
    typedef enum logic [2:0] {
        CL_NOP    = 3'd0,
        CL_PUSH   = 3'd1,
        CL_BINARY = 3'd2,
        CL_REDUCE = 3'd3,
        CL_COPY   = 3'd4
    } t_class;

    typedef struct packed {
        logic        [3:0]  op;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]  status;
        logic signed [31:0] top_value;
        logic        [6:0]  stack_count;
    } t_out_item;

    typedef struct packed {
        t_class             cls;
        logic        [3:0]  op;
        logic signed [31:0] value;
    } t_cmd;

    // Clamp a 64-bit intermediate to the signed 32-bit range.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic sat64(input logic signed [63:0] v);
        return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
    endfunction
endpackage
`default_nettype wire

// ===== src/rpn_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/rpn_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none
module rpn_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rpn_pkg::t_in_item i_item,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output rpn_pkg::t_cmd          o_cmd
);
    rpn_pkg::t_cmd r_q [rpn_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    rpn_pkg::t_cmd w_cmd;
    logic          w_push, w_pop;

    always_comb begin
        w_cmd.op    = i_item.op;
        w_cmd.value = i_item.value;
        unique case (i_item.op)
            rpn_pkg::OP_PUSH: w_cmd.cls = rpn_pkg::CL_PUSH;
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV:
                w_cmd.cls = rpn_pkg::CL_BINARY;
            rpn_pkg::OP_SUM_ALL, rpn_pkg::OP_SUB_ALL, rpn_pkg::OP_MUL_ALL:
                w_cmd.cls = rpn_pkg::CL_REDUCE;
            rpn_pkg::OP_COPY: w_cmd.cls = rpn_pkg::CL_COPY;
            default: w_cmd.cls = rpn_pkg::CL_NOP;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(rpn_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("accepted into full queue");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> r_wp == r_rp)
        else $error("queue pointers out of step");
endmodule
`default_nettype wire

// ===== src/rpn_div.sv =====
// Iterative restoring divider: signed (a << FRAC_BITS) / b, truncated, saturated.
`default_nettype none
module rpn_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_done,
    output logic signed [31:0]      o_q,
    output logic                    o_sat
);
    localparam int NW = 32 + rpn_pkg::FRAC_BITS;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] r_num;
    logic [31:0]   r_den;
    logic [32:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [SW-1:0] r_step;
    logic          r_busy, r_neg;
    logic [32:0]   w_trial;
    logic [33:0]   w_diff;
    logic signed [NW+1:0] w_sq;

    assign w_trial = {r_rem[31:0], r_num[NW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_sq    = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(NW);
                r_num  <= {(i_a[31] ? 32'(-i_a) : 32'(i_a)),
                           {rpn_pkg::FRAC_BITS{1'b0}}};
                r_den  <= i_b[31] ? 32'(-i_b) : 32'(i_b);
                r_neg  <= i_a[31] ^ i_b[31];
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                    o_q    <= rpn_pkg::clamp32(64'(w_sq));
                    o_sat  <= rpn_pkg::sat64(64'(w_sq));
                end else begin
                    r_num  <= r_num << 1;
                    r_step <= r_step - 1'b1;
                    if (!w_diff[33]) begin
                        r_rem <= w_diff[32:0];
                        r_quo <= {r_quo[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial;
                        r_quo <= {r_quo[NW-2:0], 1'b0};
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/rpn_back.sv =====
// Back end: executes queued commands against the stack memory.
`default_nettype none
module rpn_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    output logic                    o_cmd_ready,
    input  wire rpn_pkg::t_cmd      i_cmd,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rpn_pkg::t_out_item      o_item
);
    localparam int PW = rpn_pkg::PTR_W;
    localparam int CW = rpn_pkg::CNT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD1   = 10'b0000000010,
        S_RD2   = 10'b0000000100,
        S_BIN   = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_DIVW  = 10'b0000100000,
        S_RED   = 10'b0001000000,
        S_COPY  = 10'b0010000000,
        S_WRT   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state             r_state;
    rpn_pkg::t_cmd      r_cmd;
    logic [CW-1:0]      r_n;
    logic [PW-1:0]      r_idx;
    logic signed [31:0] r_a, r_b, r_res;
    logic signed [63:0] r_prod;
    logic [2:0]         r_status;
    logic               r_sat;
    logic [31:0]        r_cnt;

    logic               w_we;
    logic [PW-1:0]      w_waddr, w_raddr;
    logic [31:0]        w_wdata;
    logic signed [31:0] w_rdata;
    logic               w_div_start, w_div_done, w_div_sat;
    logic signed [31:0] w_div_q;
    logic signed [63:0] w_fl;
    logic signed [63:0] w_step;

    rpn_ram #(.WIDTH(32), .DEPTH(rpn_pkg::STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // The divisor is taken straight from the read data in the cycle it arrives.
    rpn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_a(r_a), .i_b(w_rdata), .o_done(w_div_done), .o_q(w_div_q), .o_sat(w_div_sat)
    );

    assign o_cmd_ready = (r_state == S_IDLE) && !o_valid;
    assign w_fl        = r_prod >>> rpn_pkg::FRAC_BITS;
    assign w_raddr     = r_idx;
    assign w_div_start = (r_state == S_BIN) && (r_cmd.op == rpn_pkg::OP_DIV)
                         && (w_rdata != 0);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_res;
        if (r_state == S_WRT) w_we = 1'b1;
        if (r_state == S_COPY && !r_cnt[31] && r_cnt != 0
            && r_n != CW'(rpn_pkg::STACK_DEPTH)) begin
            w_we    = 1'b1;
            w_waddr = r_n[PW-1:0];
            w_wdata = r_b;
        end
        unique case (r_cmd.op)
            rpn_pkg::OP_SUM_ALL: w_step = 64'(r_a) + 64'(w_rdata);
            rpn_pkg::OP_SUB_ALL: w_step = 64'(r_a) - 64'(w_rdata);
            default:             w_step = 64'(r_a);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_cmd_valid && o_cmd_ready) begin
                    r_cmd    <= i_cmd;
                    r_sat    <= 1'b0;
                    unique case (i_cmd.cls)
                        rpn_pkg::CL_PUSH: begin
                            if (r_n == CW'(rpn_pkg::STACK_DEPTH)) begin
                                r_status <= rpn_pkg::ST_FULL;
                                r_state  <= S_RD1;
                                r_idx    <= PW'(r_n - 1'b1);
                            end else begin
                                r_status <= rpn_pkg::ST_OK;
                                r_res    <= i_cmd.value;
                                r_idx    <= r_n[PW-1:0];
                                r_n      <= r_n + 1'b1;
                                r_state  <= S_WRT;
                            end
                        end
                        rpn_pkg::CL_BINARY, rpn_pkg::CL_COPY: begin
                            r_status <= (r_n < CW'(2)) ? rpn_pkg::ST_FEW : rpn_pkg::ST_OK;
                            r_idx    <= PW'(r_n - 1'b1);
                            r_state  <= S_RD1;
                        end
                        rpn_pkg::CL_REDUCE: begin
                            r_status <= (r_n == '0) ? rpn_pkg::ST_FEW : rpn_pkg::ST_OK;
                            r_idx    <= PW'(r_n - 1'b1);
                            r_state  <= S_RD1;
                        end
                        default: begin
                            r_status <= rpn_pkg::ST_OK;
                            r_idx    <= PW'(r_n - 1'b1);
                            r_state  <= S_RD1;
                        end
                    endcase
                end
                // Read of the top entry is issued; data arrives next cycle.
                S_RD1: begin
                    if (r_status != rpn_pkg::ST_OK || r_cmd.cls == rpn_pkg::CL_NOP) begin
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= PW'(r_n - CW'(2));
                        r_state <= S_RD2;
                    end
                end
                S_RD2: begin
                    r_a <= w_rdata;
                    if (r_cmd.cls == rpn_pkg::CL_REDUCE) begin
                        if (r_n == CW'(1)) begin
                            r_res   <= w_rdata;
                            r_idx   <= '0;
                            r_n     <= CW'(1);
                            r_state <= S_WRT;
                        end else begin
                            r_idx   <= PW'(r_n - CW'(3));
                            r_cnt   <= 32'(r_n - CW'(1));
                            r_state <= S_RED;
                        end
                    end else begin
                        r_state <= S_BIN;
                    end
                end
                S_BIN: begin
                    r_b <= w_rdata;
                    r_idx <= PW'(r_n - CW'(2));
                    if (r_cmd.cls == rpn_pkg::CL_COPY) begin
                        r_n <= r_n - CW'(2);
                        if (r_a[31])
                            r_cnt <= 32'(-((-64'(r_a)) >>> rpn_pkg::FRAC_BITS));
                        else
                            r_cnt <= 32'(r_a >>> rpn_pkg::FRAC_BITS);
                        r_state <= S_COPY;
                    end else begin
                        unique case (r_cmd.op)
                            rpn_pkg::OP_ADD: begin
                                r_res <= rpn_pkg::clamp32(64'(r_a) + 64'(w_rdata));
                                r_sat <= rpn_pkg::sat64(64'(r_a) + 64'(w_rdata));
                                r_n   <= r_n - 1'b1;
                                r_state <= S_WRT;
                            end
                            rpn_pkg::OP_SUB: begin
                                r_res <= rpn_pkg::clamp32(64'(r_a) - 64'(w_rdata));
                                r_sat <= rpn_pkg::sat64(64'(r_a) - 64'(w_rdata));
                                r_n   <= r_n - 1'b1;
                                r_state <= S_WRT;
                            end
                            rpn_pkg::OP_MUL: begin
                                r_n     <= r_n - CW'(2);
                                r_prod  <= 64'(r_a) * 64'(w_rdata);
                                r_state <= S_MUL;
                            end
                            default: begin
                                r_n     <= r_n - CW'(2);
                                r_state <= S_DIVW;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_res <= rpn_pkg::clamp32(w_fl);
                    r_sat <= r_sat | rpn_pkg::sat64(w_fl);
                    if (r_cmd.cls == rpn_pkg::CL_REDUCE) begin
                        r_a <= rpn_pkg::clamp32(w_fl);
                        r_idx <= r_idx - 1'b1;
                        r_state <= S_RED;
                    end else begin
                        r_n <= r_n + 1'b1;
                        r_state <= S_WRT;
                    end
                end
                S_DIVW: begin
                    if (r_b == 0) begin
                        r_res    <= r_a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        r_status <= rpn_pkg::ST_DIV0;
                        r_n      <= r_n + 1'b1;
                        r_state  <= S_WRT;
                    end else if (w_div_done) begin
                        r_res   <= w_div_q;
                        r_sat   <= w_div_sat;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_WRT;
                    end
                end
                // One lower entry per pass; for multiply the read data is used only in S_RED,
                // and each pass also goes through S_MUL, since the product takes an extra stage.
                S_RED: begin
                    if (r_cnt == 0) begin
                        r_res   <= r_a;
                        r_idx   <= '0;
                        r_n     <= CW'(1);
                        r_state <= S_WRT;
                    end else if (r_cmd.op == rpn_pkg::OP_MUL_ALL) begin
                        r_prod  <= 64'(r_a) * 64'(w_rdata);
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_a   <= rpn_pkg::clamp32(w_step);
                        r_sat <= r_sat | rpn_pkg::sat64(w_step);
                        r_cnt <= r_cnt - 1'b1;
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_COPY: begin
                    if (r_cnt[31] || r_cnt == 0) begin
                        r_idx   <= PW'(r_n - 1'b1);
                        r_state <= S_RD1;
                        r_cmd.cls <= rpn_pkg::CL_NOP;
                    end else if (r_n == CW'(rpn_pkg::STACK_DEPTH)) begin
                        r_status <= rpn_pkg::ST_FULL;
                        r_idx    <= PW'(r_n - 1'b1);
                        r_state  <= S_RD1;
                    end else begin
                        r_n   <= r_n + 1'b1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_WRT: begin
                    r_idx   <= PW'(r_n - 1'b1);
                    r_state <= S_RD1;
                    r_cmd.cls <= rpn_pkg::CL_NOP;
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_item.top_value   <= (r_n == '0) ? 32'sd0 : w_rdata;
                        o_item.stack_count <= 7'(r_n);
                        o_item.status <= (r_sat && r_status == rpn_pkg::ST_OK)
                                         ? rpn_pkg::ST_SAT : r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(rpn_pkg::STACK_DEPTH)) else $error("stack count overflow");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
endmodule
`default_nettype wire

// ===== src/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: command front end, execute back end.
// One command beat enters on i_valid/o_ready and carries op and a Q16.16 value.
// Every command yields exactly one result beat on o_valid/i_ready with the
// status, the new top of stack (zero when empty) and the new entry count.
// A two-entry queue sits between the front end and the execute engine, so
// commands are taken while the engine works or a result waits to be taken.
// Divide runs on the one-bit-a-cycle, 48-step divider; the product reduction
// passes through the multiply stage for each entry, and copy pushes its
// entries one at a time, limited by the single write port of the stack memory.
// Throughput is one command at a time in the engine; the next queued command
// starts at the edge after the result beat is taken.
// Reset clears the entry count and control state; the stack memory is not
// cleared because only entries below the count are ever used.
// When the receiver stalls, the result holds and the engine takes no new
// command until it is taken; the queue keeps accepting until it holds two.
`default_nettype none
module rpn_stack_calculator_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire rpn_pkg::t_in_item  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rpn_pkg::t_out_item      o_data
);
    logic          w_cmd_valid, w_cmd_ready;
    rpn_pkg::t_cmd w_cmd;

    // Front end classifies and buffers incoming commands.
    rpn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_data), .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready),
        .o_cmd(w_cmd)
    );

    // Back end owns the stack memory, the divider and the result register.
    rpn_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd), .o_valid(o_valid),
        .i_ready(i_ready), .o_item(o_data)
    );
endmodule
`default_nettype wire

// ===== tb/rpn_stack_calculator_core_test.sv =====
// Self-checking testbench for the RPN stack calculator core.
`timescale 1ns / 100ps
`default_nettype none
module rpn_stack_calculator_core_test;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    rpn_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_ready;
    rpn_pkg::t_out_item o_data;

    rpn_stack_calculator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Predicted calculator state, kept apart from the design.
    logic signed [31:0] calc_stack [rpn_pkg::STACK_DEPTH];
    int                 calc_depth;
    rpn_pkg::t_out_item pending_results [$];

    int  error_count;
    int  cmd_beats;
    int  result_beats;
    int  idle_cycles;
    bit  sink_enable;
    int  op_seen [16];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a wide value to the signed 32-bit range and note saturation.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 inout bit sat);
        if (v > 66'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Fixed-point product; the arithmetic shift floors toward minus infinity.
    function automatic logic signed [31:0] fx_product(input logic signed [31:0] a,
                                                      input logic signed [31:0] b,
                                                      inout bit sat);
        logic signed [65:0] p;
        p = (66'(a) * 66'(b)) >>> rpn_pkg::FRAC_BITS;
        return sat32(p, sat);
    endfunction

    // Advance the predicted stack by one command and return the expected beat.
    function automatic rpn_pkg::t_out_item predict_command(input rpn_pkg::t_in_item cmd);
        rpn_pkg::t_out_item res;
        logic [2:0]         status;
        bit                 sat;
        logic signed [31:0] a, b, r, acc, v;
        logic signed [65:0] num;
        int                 cnt;
        status = rpn_pkg::ST_OK;
        sat    = 1'b0;
        case (cmd.op)
            rpn_pkg::OP_PUSH: begin
                if (calc_depth >= rpn_pkg::STACK_DEPTH) status = rpn_pkg::ST_FULL;
                else begin
                    calc_stack[calc_depth] = cmd.value;
                    calc_depth++;
                end
            end
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                if (calc_depth < 2) status = rpn_pkg::ST_FEW;
                else begin
                    a = calc_stack[calc_depth-1];
                    b = calc_stack[calc_depth-2];
                    if (cmd.op == rpn_pkg::OP_ADD) r = sat32(66'(a) + 66'(b), sat);
                    else if (cmd.op == rpn_pkg::OP_SUB) r = sat32(66'(a) - 66'(b), sat);
                    else if (cmd.op == rpn_pkg::OP_MUL) r = fx_product(a, b, sat);
                    else if (b == 0) begin
                        r = (a < 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                        status = rpn_pkg::ST_DIV0;
                    end else begin
                        // SystemVerilog signed division truncates toward zero.
                        num = 66'(a) <<< rpn_pkg::FRAC_BITS;
                        r = sat32(num / 66'(b), sat);
                    end
                    calc_depth -= 1;
                    calc_stack[calc_depth-1] = r;
                end
            end
            rpn_pkg::OP_SUM_ALL, rpn_pkg::OP_SUB_ALL, rpn_pkg::OP_MUL_ALL: begin
                if (calc_depth < 1) status = rpn_pkg::ST_FEW;
                else begin
                    // The accumulator starts fresh and saturates at every step.
                    acc = calc_stack[calc_depth-1];
                    for (int i = calc_depth - 2; i >= 0; i--) begin
                        if (cmd.op == rpn_pkg::OP_SUM_ALL)
                            acc = sat32(66'(acc) + 66'(calc_stack[i]), sat);
                        else if (cmd.op == rpn_pkg::OP_SUB_ALL)
                            acc = sat32(66'(acc) - 66'(calc_stack[i]), sat);
                        else
                            acc = fx_product(acc, calc_stack[i], sat);
                    end
                    calc_stack[0] = acc;
                    calc_depth = 1;
                end
            end
            rpn_pkg::OP_COPY: begin
                if (calc_depth < 2) status = rpn_pkg::ST_FEW;
                else begin
                    a = calc_stack[calc_depth-1];
                    v = calc_stack[calc_depth-2];
                    calc_depth -= 2;
                    // Integer part of the count, truncated toward zero.
                    if (a >= 0) cnt = int'(a >>> rpn_pkg::FRAC_BITS);
                    else cnt = -int'((-64'(a)) >> rpn_pkg::FRAC_BITS);
                    while (cnt > 0) begin
                        if (calc_depth >= rpn_pkg::STACK_DEPTH) begin
                            status = rpn_pkg::ST_FULL;
                            break;
                        end
                        calc_stack[calc_depth] = v;
                        calc_depth++;
                        cnt--;
                    end
                end
            end
            default: ;  // unknown codes leave the stack alone
        endcase
        if (sat && status == rpn_pkg::ST_OK) status = rpn_pkg::ST_SAT;
        res.status      = status;
        res.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : 32'sd0;
        res.stack_count = 7'(calc_depth);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one command beat; the prediction is made when it is accepted.
    // Called and left at a falling edge; valid only drops when a gap follows.
    task automatic send_command(input logic [3:0] op, input logic signed [31:0] value,
                                input bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? gap_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data.op    <= op;
        i_data.value <= value;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(predict_command('{op: op, value: value}));
        op_seen[op]++;
        cmd_beats++;
        @(negedge i_clk);
    endtask

    // Result receiver with random stalls; each beat is checked on arrival.
    always @(posedge i_clk) begin
        rpn_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            result_beats++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat %p", $time, o_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_data.status);
                    error_count++;
                end
                if (o_data.top_value !== want.top_value) begin
                    $display("%0t: top_value expected %h actual %h", $time,
                             want.top_value, o_data.top_value);
                    error_count++;
                end
                if (o_data.stack_count !== want.stack_count) begin
                    $display("%0t: stack_count expected %0d actual %0d", $time,
                             want.stack_count, o_data.stack_count);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!sink_enable) i_ready <= 1'b1;
        else if (i_ready && $urandom_range(0, 99) < 12) i_ready <= 1'b0;
        else if (!i_ready) i_ready <= ($urandom_range(0, 99) < ($urandom_range(0, 9) ? 40 : 4));
        else i_ready <= 1'b1;
    end

    // Watchdog: too long without any accepted beat ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding", $time,
                         pending_results.size());
                $display("rpn_stack_calculator_core_test: FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_value();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3, 4: return $signed(32'($urandom_range(0, 8) << rpn_pkg::FRAC_BITS))
                         - 32'sd4 * 32'sh1_0000;
            5, 6: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    // Clear the stack by reducing it and dropping the single result.
    task automatic drain_stack();
        if (calc_depth > 0) send_command(rpn_pkg::OP_SUM_ALL, 32'sd0);
        if (calc_depth > 0) begin
            send_command(rpn_pkg::OP_PUSH, 32'sd0);
            send_command(rpn_pkg::OP_COPY, 32'sd0);
        end
    endtask

    task automatic test_operand_shortage();
        send_command(rpn_pkg::OP_ADD, 32'sd0);
        send_command(rpn_pkg::OP_SUM_ALL, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh0001_0000);
        send_command(rpn_pkg::OP_DIV, 32'sd0);
        send_command(rpn_pkg::OP_COPY, 32'sd0);
        send_command(4'd9, 32'sd5);
        send_command(4'd15, $signed(32'hFFFF_FFFF));
        drain_stack();
    endtask

    task automatic test_binary_extremes();
        send_command(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_command(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_command(rpn_pkg::OP_ADD, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh8000_0000);
        send_command(rpn_pkg::OP_SUB, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh8000_0000);
        send_command(rpn_pkg::OP_MUL, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sd0);
        send_command(rpn_pkg::OP_DIV, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh8000_0000);
        send_command(rpn_pkg::OP_DIV, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, -32'sh0003_0000);
        send_command(rpn_pkg::OP_PUSH, 32'sh0007_0000);
        send_command(rpn_pkg::OP_DIV, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, -32'sd3);
        send_command(rpn_pkg::OP_MUL, 32'sd0);
        drain_stack();
    endtask

    task automatic test_reductions_and_copy();
        send_command(rpn_pkg::OP_PUSH, 32'sh4000_0000);
        send_command(rpn_pkg::OP_PUSH, -32'sh0002_8000);
        send_command(rpn_pkg::OP_COPY, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh0002_0000);
        send_command(rpn_pkg::OP_MUL_ALL, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh7000_0000);
        send_command(rpn_pkg::OP_SUB_ALL, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh0050_0000);
        send_command(rpn_pkg::OP_COPY, 32'sd0);
        send_command(rpn_pkg::OP_PUSH, 32'sh1234_5678);
        send_command(rpn_pkg::OP_SUM_ALL, 32'sd0);
        drain_stack();
    endtask

    // Build random expression chains; occasionally fill the stack to the top.
    task automatic test_random_programs(input int n_items);
        int roll;
        logic [3:0] op;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) op = 4'($urandom_range(9, 15));
            else if (roll < 40 || calc_depth < 2) op = rpn_pkg::OP_PUSH;
            else if (roll < 80) op = 4'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_DIV));
            else if (roll < 90)
                op = 4'($urandom_range(rpn_pkg::OP_SUM_ALL, rpn_pkg::OP_MUL_ALL));
            else op = rpn_pkg::OP_COPY;
            if (op == rpn_pkg::OP_COPY && $urandom_range(0, 1))
                send_command(rpn_pkg::OP_PUSH,
                             $signed(32'($urandom_range(0, 70) << rpn_pkg::FRAC_BITS)));
            send_command(op, rand_value(), k % 97 > 20);
        end
    endtask

    initial begin
        error_count = 0;
        cmd_beats = 0;
        result_beats = 0;
        idle_cycles = 0;
        calc_depth = 0;
        sink_enable = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b1;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_operand_shortage();
        sink_enable = 1'b1;
        test_binary_extremes();
        test_reductions_and_copy();
        test_random_programs(700);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Ran %0d commands and checked %0d results (push %0d, div %0d, copy %0d).",
                 cmd_beats, result_beats, op_seen[rpn_pkg::OP_PUSH],
                 op_seen[rpn_pkg::OP_DIV], op_seen[rpn_pkg::OP_COPY]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("rpn_stack_calculator_core_test: PASS");
        end else begin
            $display("rpn_stack_calculator_core_test: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== rpn_stack_calculator_core.f =====
src/rpn_pkg.sv
src/rpn_ram.sv
src/rpn_front.sv
src/rpn_div.sv
src/rpn_back.sv
src/rpn_stack_calculator_core.sv
tb/rpn_stack_calculator_core_test.sv
